/* rtl/core/power_running_statistics_macros.svh */
// Assertion macros shared by the power running statistics checkers.
// Has no dependencies; include it with the bare file name.
`ifndef POWER_RUNNING_STATISTICS_MACROS_SVH
`define POWER_RUNNING_STATISTICS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/prs_pkg.sv */
// Shared widths, defaults and controller to datapath command types for the
// power running statistics block. No dependencies.
package prs_pkg;

   localparam int ENERGY_WIDTH   = 64;
   localparam int INTERVAL_WIDTH = 32;
   localparam int POWER_WIDTH    = 48;
   localparam int SAMPLE_WIDTH   = 32;
   localparam int DEV_WIDTH      = 64;
   localparam int HALF_WIDTH     = POWER_WIDTH / 2;
   localparam int PRODUCT_WIDTH  = 2 * POWER_WIDTH;

   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int COUNT_BITS_DEFAULT = 32;

   localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = 32'd1000;

   localparam int DIV_STEPS = POWER_WIDTH;
   localparam int MUL_STEPS = 5;
   localparam int STEP_BITS = $clog2(DIV_STEPS);

   typedef struct packed {
      logic accept;
      logic div_load_power;
      logic div_load_mean;
      logic div_step;
      logic take_power;
      logic take_mean;
      logic mul_load;
      logic mul_step;
      logic publish;
   } prs_cmd_type;

   typedef struct packed {
      logic baseline_taken;
   } prs_status_type;

endpackage

/* rtl/core/prs_divider.sv */
// Bit-serial restoring divider giving a 48-bit quotient, one bit per step.
// Depends on prs_pkg.
module prs_divider
   import prs_pkg::*;
#(
   parameter int DIV_WIDTH = INTERVAL_WIDTH
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic                   step,
   input  logic [DIV_WIDTH-1:0]   load_rem,
   input  logic [POWER_WIDTH-1:0] load_quo,
   input  logic [DIV_WIDTH-1:0]   load_div,
   output logic [POWER_WIDTH-1:0] quotient
);

   logic [DIV_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]   div_ff, div_in;
   logic [POWER_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_WIDTH:0]     trial;
   logic [DIV_WIDTH:0]     trial_less;
   logic                   fits;

   always_comb begin
      trial      = {rem_ff, quo_ff[POWER_WIDTH-1]};
      trial_less = trial - {1'b0, div_ff};
      fits       = trial >= {1'b0, div_ff};
      rem_in     = rem_ff;
      div_in     = div_ff;
      quo_in     = quo_ff;
      if (load) begin
         rem_in = load_rem;
         div_in = load_div;
         quo_in = load_quo;
      end else if (step) begin
         rem_in = fits ? trial_less[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         quo_in = {quo_ff[POWER_WIDTH-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

/* rtl/core/prs_multiplier.sv */
// Iterative 48 by 48 multiplier built from one 24 by 24 multiplier, one
// partial product per step with a registered accumulate. Depends on prs_pkg.
module prs_multiplier
   import prs_pkg::*;
(
   input  logic                     clock,
   input  logic                     load,
   input  logic                     step,
   input  logic [POWER_WIDTH-1:0]   operand_a,
   input  logic [POWER_WIDTH-1:0]   operand_b,
   output logic [PRODUCT_WIDTH-1:0] product
);

   logic [POWER_WIDTH-1:0]   a_ff, a_in;
   logic [POWER_WIDTH-1:0]   b_ff, b_in;
   logic [1:0]               idx_ff, idx_in;
   logic [POWER_WIDTH-1:0]   part_ff, part_in;
   logic [1:0]               weight_ff, weight_in;
   logic                     part_valid_ff, part_valid_in;
   logic [PRODUCT_WIDTH-1:0] acc_ff, acc_in;
   logic [HALF_WIDTH-1:0]    half_a;
   logic [HALF_WIDTH-1:0]    half_b;
   logic [PRODUCT_WIDTH-1:0] shifted;

   always_comb begin
      half_a = idx_ff[0] ? a_ff[POWER_WIDTH-1:HALF_WIDTH] : a_ff[HALF_WIDTH-1:0];
      half_b = idx_ff[1] ? b_ff[POWER_WIDTH-1:HALF_WIDTH] : b_ff[HALF_WIDTH-1:0];
      case (weight_ff)
         2'd0:    shifted = PRODUCT_WIDTH'(part_ff);
         2'd1:    shifted = PRODUCT_WIDTH'(part_ff) << HALF_WIDTH;
         default: shifted = PRODUCT_WIDTH'(part_ff) << POWER_WIDTH;
      endcase
      a_in          = a_ff;
      b_in          = b_ff;
      idx_in        = idx_ff;
      part_in       = part_ff;
      weight_in     = weight_ff;
      part_valid_in = part_valid_ff;
      acc_in        = acc_ff;
      if (load) begin
         a_in          = operand_a;
         b_in          = operand_b;
         idx_in        = 2'd0;
         part_valid_in = 1'b0;
         acc_in        = '0;
      end else if (step) begin
         part_in       = POWER_WIDTH'(half_a) * POWER_WIDTH'(half_b);
         weight_in     = 2'(idx_ff[0]) + 2'(idx_ff[1]);
         idx_in        = idx_ff + 2'd1;
         part_valid_in = 1'b1;
         if (part_valid_ff) begin
            acc_in = acc_ff + shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      idx_ff        <= idx_in;
      part_ff       <= part_in;
      weight_ff     <= weight_in;
      part_valid_ff <= part_valid_in;
      acc_ff        <= acc_in;
   end

   assign product = acc_ff;

endmodule

/* rtl/core/prs_datapath.sv */
// Datapath: statistics registers, shared divider, multiplier and the result
// register. Depends on prs_pkg, prs_divider and prs_multiplier.
module prs_datapath
   import prs_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  prs_cmd_type               cmd,
   output prs_status_type            status,
   input  logic [ENERGY_WIDTH-1:0]   req_energy_reading,
   input  logic                      csr_write,
   input  logic [INTERVAL_WIDTH-1:0] csr_interval_us,
   output logic [POWER_WIDTH-1:0]    rsp_power_now,
   output logic [SAMPLE_WIDTH-1:0]   rsp_samples_seen,
   output logic [POWER_WIDTH-1:0]    rsp_power_lowest,
   output logic [POWER_WIDTH-1:0]    rsp_power_highest,
   output logic [POWER_WIDTH-1:0]    rsp_power_mean,
   output logic [DEV_WIDTH-1:0]      rsp_squared_deviation_sum
);

   localparam int DIV_WIDTH = (COUNT_BITS > INTERVAL_WIDTH) ? COUNT_BITS : INTERVAL_WIDTH;
   localparam int SAT_SHIFT = POWER_WIDTH - FRAC_BITS;

   logic [INTERVAL_WIDTH-1:0] interval_ff, interval_in;
   logic                      baseline_ff, baseline_in;
   logic [ENERGY_WIDTH-1:0]   prev_ff, prev_in;
   logic [ENERGY_WIDTH-1:0]   diff_ff, diff_in;
   logic                      sat_ff, sat_in;
   logic [POWER_WIDTH-1:0]    power_ff, power_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [POWER_WIDTH-1:0]    low_ff, low_in;
   logic [POWER_WIDTH-1:0]    high_ff, high_in;
   logic [POWER_WIDTH-1:0]    mean_ff, mean_in;
   logic                      ge_ff, ge_in;
   logic [POWER_WIDTH-1:0]    delta_ff, delta_in;
   logic [DEV_WIDTH-1:0]      dev_ff, dev_in;

   logic [POWER_WIDTH-1:0]    out_power_ff, out_power_in;
   logic [SAMPLE_WIDTH-1:0]   out_samples_ff, out_samples_in;
   logic [POWER_WIDTH-1:0]    out_low_ff, out_low_in;
   logic [POWER_WIDTH-1:0]    out_high_ff, out_high_in;
   logic [POWER_WIDTH-1:0]    out_mean_ff, out_mean_in;
   logic [DEV_WIDTH-1:0]      out_dev_ff, out_dev_in;

   logic                      div_load;
   logic [DIV_WIDTH-1:0]      div_load_rem;
   logic [POWER_WIDTH-1:0]    div_load_quo;
   logic [DIV_WIDTH-1:0]      div_load_div;
   logic [POWER_WIDTH-1:0]    quotient;
   logic [POWER_WIDTH-1:0]    abs_delta;
   logic [PRODUCT_WIDTH-1:0]  product;
   logic [PRODUCT_WIDTH-1:0]  scaled_wide;
   logic [DEV_WIDTH-1:0]      scaled;
   logic [DEV_WIDTH:0]        dev_sum;
   logic [DEV_WIDTH-1:0]      dev_next;

   always_comb begin
      abs_delta = (power_ff >= mean_ff) ? power_ff - mean_ff : mean_ff - power_ff;

      div_load     = cmd.div_load_power | cmd.div_load_mean;
      div_load_rem = cmd.div_load_power ? DIV_WIDTH'(diff_ff >> SAT_SHIFT) : '0;
      div_load_quo = cmd.div_load_power ? POWER_WIDTH'(diff_ff << FRAC_BITS) : abs_delta;
      div_load_div = cmd.div_load_power ? DIV_WIDTH'(interval_ff) : DIV_WIDTH'(count_ff);

      scaled_wide = product >> FRAC_BITS;
      scaled      = (|scaled_wide[PRODUCT_WIDTH-1:DEV_WIDTH]) ? '1
                                                              : scaled_wide[DEV_WIDTH-1:0];
      dev_sum     = {1'b0, dev_ff} + {1'b0, scaled};
      dev_next    = dev_sum[DEV_WIDTH] ? '1 : dev_sum[DEV_WIDTH-1:0];
   end

   always_comb begin
      interval_in    = interval_ff;
      baseline_in    = baseline_ff;
      prev_in        = prev_ff;
      diff_in        = diff_ff;
      sat_in         = sat_ff;
      power_in       = power_ff;
      count_in       = count_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      mean_in        = mean_ff;
      ge_in          = ge_ff;
      delta_in       = delta_ff;
      dev_in         = dev_ff;
      out_power_in   = out_power_ff;
      out_samples_in = out_samples_ff;
      out_low_in     = out_low_ff;
      out_high_in    = out_high_ff;
      out_mean_in    = out_mean_ff;
      out_dev_in     = out_dev_ff;
      if (csr_write) begin
         interval_in = csr_interval_us;
      end
      if (cmd.accept) begin
         baseline_in = 1'b1;
         prev_in     = req_energy_reading;
         diff_in     = req_energy_reading - prev_ff;
      end
      if (cmd.div_load_power) begin
         sat_in = (diff_ff >> SAT_SHIFT) >= ENERGY_WIDTH'(interval_ff);
      end
      if (cmd.take_power) begin
         power_in = sat_ff ? '1 : quotient;
         if (count_ff != '1) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
      if (cmd.div_load_mean) begin
         if (power_ff > high_ff) begin
            high_in = power_ff;
         end
         if (power_ff < low_ff) begin
            low_in = power_ff;
         end
         ge_in    = power_ff >= mean_ff;
         delta_in = abs_delta;
      end
      if (cmd.take_mean) begin
         mean_in = ge_ff ? mean_ff + quotient : mean_ff - quotient;
      end
      if (cmd.publish) begin
         dev_in         = dev_next;
         out_power_in   = power_ff;
         out_samples_in = SAMPLE_WIDTH'(count_ff);
         out_low_in     = low_ff;
         out_high_in    = high_ff;
         out_mean_in    = mean_ff;
         out_dev_in     = dev_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         baseline_ff <= 1'b0;
         prev_ff     <= '0;
         count_ff    <= '0;
         low_ff      <= '1;
         high_ff     <= '0;
         mean_ff     <= '0;
         dev_ff      <= '0;
      end else begin
         interval_ff <= interval_in;
         baseline_ff <= baseline_in;
         prev_ff     <= prev_in;
         count_ff    <= count_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         mean_ff     <= mean_in;
         dev_ff      <= dev_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff        <= diff_in;
      sat_ff         <= sat_in;
      power_ff       <= power_in;
      ge_ff          <= ge_in;
      delta_ff       <= delta_in;
      out_power_ff   <= out_power_in;
      out_samples_ff <= out_samples_in;
      out_low_ff     <= out_low_in;
      out_high_ff    <= out_high_in;
      out_mean_ff    <= out_mean_in;
      out_dev_ff     <= out_dev_in;
   end

   prs_divider #(
      .DIV_WIDTH (DIV_WIDTH)
   ) u_divider (
      .clock    (clock),
      .load     (div_load),
      .step     (cmd.div_step),
      .load_rem (div_load_rem),
      .load_quo (div_load_quo),
      .load_div (div_load_div),
      .quotient (quotient)
   );

   prs_multiplier u_multiplier (
      .clock     (clock),
      .load      (cmd.mul_load),
      .step      (cmd.mul_step),
      .operand_a (abs_delta),
      .operand_b (delta_ff),
      .product   (product)
   );

   assign status.baseline_taken    = baseline_ff;
   assign rsp_power_now             = out_power_ff;
   assign rsp_samples_seen          = out_samples_ff;
   assign rsp_power_lowest          = out_low_ff;
   assign rsp_power_highest         = out_high_ff;
   assign rsp_power_mean            = out_mean_ff;
   assign rsp_squared_deviation_sum = out_dev_ff;

endmodule

/* rtl/core/prs_controller.sv */
// Sequencing state machine: handshakes and the command for each step of
// the datapath. Depends on prs_pkg.
module prs_controller
   import prs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  prs_status_type status,
   output prs_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_POWER_DIV,
      S_POWER_TAKE,
      S_MEAN_SETUP,
      S_MEAN_DIV,
      S_MEAN_TAKE,
      S_MUL_SETUP,
      S_MUL,
      S_FINISH
   } state_type;

   localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(DIV_STEPS - 1);
   localparam logic [STEP_BITS-1:0] MUL_LAST = STEP_BITS'(MUL_STEPS - 1);

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.baseline_taken) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            cmd.div_load_power = 1'b1;
            step_in            = '0;
            state_in           = S_POWER_DIV;
         end
         S_POWER_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == DIV_LAST) begin
               state_in = S_POWER_TAKE;
            end
         end
         S_POWER_TAKE: begin
            cmd.take_power = 1'b1;
            state_in       = S_MEAN_SETUP;
         end
         S_MEAN_SETUP: begin
            cmd.div_load_mean = 1'b1;
            step_in           = '0;
            state_in          = S_MEAN_DIV;
         end
         S_MEAN_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == DIV_LAST) begin
               state_in = S_MEAN_TAKE;
            end
         end
         S_MEAN_TAKE: begin
            cmd.take_mean = 1'b1;
            state_in      = S_MUL_SETUP;
         end
         S_MUL_SETUP: begin
            cmd.mul_load = 1'b1;
            step_in      = '0;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == MUL_LAST) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/power_running_statistics.sv */
// Top level of the power running statistics block.
// Depends on prs_pkg, prs_controller and prs_datapath.
//
// Each energy reading is taken when the block is idle. The
// first reading after reset only sets the baseline and gives no result, and
// the block is ready again in the next cycle. Every later reading gives one
// result, and no new reading is taken until that result is published; the
// result waits to be published while an earlier one is still stalled. Most
// of the work is the shared bit-serial divider, which runs twice at one
// quotient bit per cycle, once for the power and once for the mean update;
// the squared deviation product is then built on a 24 by 24 multiplier. A
// finished result waits in its own register while the next reading is
// worked on. The interval register is written through the csr port, which
// is always ready; write it only while the block is idle.
module power_running_statistics
   import prs_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ENERGY_WIDTH-1:0]   req_energy_reading,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [POWER_WIDTH-1:0]    rsp_power_now,
   output logic [SAMPLE_WIDTH-1:0]   rsp_samples_seen,
   output logic [POWER_WIDTH-1:0]    rsp_power_lowest,
   output logic [POWER_WIDTH-1:0]    rsp_power_highest,
   output logic [POWER_WIDTH-1:0]    rsp_power_mean,
   output logic [DEV_WIDTH-1:0]      rsp_squared_deviation_sum,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [INTERVAL_WIDTH-1:0] csr_interval_us
);

   prs_cmd_type    cmd;
   prs_status_type status;
   logic           csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   prs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   prs_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .req_energy_reading        (req_energy_reading),
      .csr_write                 (csr_write),
      .csr_interval_us           (csr_interval_us),
      .rsp_power_now             (rsp_power_now),
      .rsp_samples_seen          (rsp_samples_seen),
      .rsp_power_lowest          (rsp_power_lowest),
      .rsp_power_highest         (rsp_power_highest),
      .rsp_power_mean            (rsp_power_mean),
      .rsp_squared_deviation_sum (rsp_squared_deviation_sum)
   );

endmodule

/* rtl/core/prs_checker.sv */
// Port-level checks for the power running statistics block, bound to the
// top level. Depends on prs_pkg and power_running_statistics_macros.svh.
`include "power_running_statistics_macros.svh"

module prs_checker
   import prs_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [ENERGY_WIDTH-1:0]   req_energy_reading,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [POWER_WIDTH-1:0]    rsp_power_now,
   input logic [SAMPLE_WIDTH-1:0]   rsp_samples_seen,
   input logic [POWER_WIDTH-1:0]    rsp_power_lowest,
   input logic [POWER_WIDTH-1:0]    rsp_power_highest,
   input logic [POWER_WIDTH-1:0]    rsp_power_mean,
   input logic [DEV_WIDTH-1:0]      rsp_squared_deviation_sum,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [INTERVAL_WIDTH-1:0] csr_interval_us
);

   `PRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_power_now) && $stable(rsp_squared_deviation_sum), "Stalled result changed or was dropped.")

   `PRS_ASSERT_NOW(a_now_in_range, clock, reset, rsp_valid, rsp_power_lowest <= rsp_power_now && rsp_power_now <= rsp_power_highest, "Current power lies outside the minimum and maximum.")

   `PRS_ASSERT_NOW(a_mean_in_range, clock, reset, rsp_valid, rsp_power_lowest <= rsp_power_mean && rsp_power_mean <= rsp_power_highest, "Mean power lies outside the minimum and maximum.")

   `PRS_ASSERT_NOW(a_result_while_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "A result appeared without the block having been busy.")

endmodule

bind power_running_statistics prs_checker u_prs_checker (.*);

/* sim/power_running_statistics_tb.sv */
// Self-checking testbench for power_running_statistics: directed and random energy
// readings, checked field by field against a predictor of the running statistics.
// Depends on prs_pkg and the power_running_statistics RTL.
`timescale 1ns / 100ps

module power_running_statistics_tb;
   import prs_pkg::*;

   localparam int FRAC           = FRAC_BITS_DEFAULT;
   localparam int SETTLE_CYCLES  = 120;
   localparam int QUIET_LIMIT    = 4000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 134;
   localparam int SQUEEZE_AT     = 300;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int HEAD_ROWS      = 16;
   localparam int ROWS           = 24;

   typedef struct packed {
      logic [POWER_WIDTH-1:0]  power_now;
      logic [SAMPLE_WIDTH-1:0] samples_seen;
      logic [POWER_WIDTH-1:0]  power_lowest;
      logic [POWER_WIDTH-1:0]  power_highest;
      logic [POWER_WIDTH-1:0]  power_mean;
      logic [DEV_WIDTH-1:0]    squared_deviation_sum;
   } power_summary_type;

   typedef enum logic [1:0] {
      ROW_READING_AT,
      ROW_READING_STEP,
      ROW_INTERVAL
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [63:0]           value;
      bit                    typed;
      power_summary_type     result;
   } script_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [ENERGY_WIDTH-1:0]   req_energy_reading = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [POWER_WIDTH-1:0]    rsp_power_now;
   logic [SAMPLE_WIDTH-1:0]   rsp_samples_seen;
   logic [POWER_WIDTH-1:0]    rsp_power_lowest;
   logic [POWER_WIDTH-1:0]    rsp_power_highest;
   logic [POWER_WIDTH-1:0]    rsp_power_mean;
   logic [DEV_WIDTH-1:0]      rsp_squared_deviation_sum;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [INTERVAL_WIDTH-1:0] csr_interval_us = '0;

   // Predictor state.
   bit                        seen_baseline = 1'b0;
   logic [ENERGY_WIDTH-1:0]   last_energy = '0;
   logic [SAMPLE_WIDTH-1:0]   sample_count = '0;
   logic [POWER_WIDTH-1:0]    lowest_seen = '1;
   logic [POWER_WIDTH-1:0]    highest_seen = '0;
   logic [POWER_WIDTH-1:0]    mean_now = '0;
   logic [DEV_WIDTH-1:0]      deviation_total = '0;
   logic [INTERVAL_WIDTH-1:0] interval_cfg = INTERVAL_RESET;

   power_summary_type         awaited_summaries[$];
   script_row_type            script[ROWS];
   logic [ENERGY_WIDTH-1:0]   sent_energy = '0;
   bit                        calm = 1'b0;
   int                        mismatches = 0;
   int                        results_taken = 0;
   int                        hold_left = 0;
   int                        quiet_cycles = 0;

   power_running_statistics dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_energy_reading        (req_energy_reading),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_power_now             (rsp_power_now),
      .rsp_samples_seen          (rsp_samples_seen),
      .rsp_power_lowest          (rsp_power_lowest),
      .rsp_power_highest         (rsp_power_highest),
      .rsp_power_mean            (rsp_power_mean),
      .rsp_squared_deviation_sum (rsp_squared_deviation_sum),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_interval_us           (csr_interval_us)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Returns 1 and the statistics when the reading yields a power sample.
   function automatic bit advance_statistics(input logic [ENERGY_WIDTH-1:0] reading,
                                             output power_summary_type summary);
      logic [ENERGY_WIDTH-1:0]      diff;
      logic [ENERGY_WIDTH+FRAC-1:0] quotient;
      logic [POWER_WIDTH-1:0]       power, prior_mean, spread_new, spread_old;
      logic [PRODUCT_WIDTH-1:0]     scaled;
      logic [DEV_WIDTH-1:0]         increment;
      logic [DEV_WIDTH:0]           total;
      summary = '0;
      if (!seen_baseline) begin
         seen_baseline = 1'b1;
         last_energy = reading;
         return 1'b0;
      end
      diff = reading - last_energy;
      last_energy = reading;
      if (interval_cfg == 0) begin
         power = '1;
      end else begin
         quotient = {diff, {FRAC{1'b0}}} / interval_cfg;
         power = (quotient >> POWER_WIDTH) != 0 ? '1 : quotient[POWER_WIDTH-1:0];
      end
      if (power > highest_seen) begin
         highest_seen = power;
      end
      if (power < lowest_seen) begin
         lowest_seen = power;
      end
      prior_mean = mean_now;
      if (sample_count != '1) begin
         sample_count++;
      end
      if (sample_count == 1) begin
         mean_now = power;
      end else if (power >= prior_mean) begin
         mean_now = prior_mean + (power - prior_mean) / sample_count;
      end else begin
         mean_now = prior_mean - (prior_mean - power) / sample_count;
      end
      spread_new = power >= mean_now ? power - mean_now : mean_now - power;
      spread_old = power >= prior_mean ? power - prior_mean : prior_mean - power;
      scaled = (PRODUCT_WIDTH'(spread_new) * PRODUCT_WIDTH'(spread_old)) >> FRAC;
      increment = (scaled >> DEV_WIDTH) != 0 ? '1 : scaled[DEV_WIDTH-1:0];
      total = {1'b0, deviation_total} + {1'b0, increment};
      deviation_total = total[DEV_WIDTH] ? '1 : total[DEV_WIDTH-1:0];
      summary.power_now = power;
      summary.samples_seen = sample_count;
      summary.power_lowest = lowest_seen;
      summary.power_highest = highest_seen;
      summary.power_mean = mean_now;
      summary.squared_deviation_sum = deviation_total;
      return 1'b1;
   endfunction

   task automatic send_reading(input logic [ENERGY_WIDTH-1:0] reading, input bit typed,
                               input power_summary_type typed_result);
      int                gap;
      power_summary_type predicted;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_energy_reading <= reading;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sent_energy = reading;
      if (advance_statistics(reading, predicted)) begin
         awaited_summaries.push_back(typed ? typed_result : predicted);
      end
   endtask

   // The interval may only change once the block has drained.
   task automatic write_interval(input logic [INTERVAL_WIDTH-1:0] interval);
      req_valid <= 1'b0;
      while (awaited_summaries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_interval_us <= interval;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      interval_cfg = interval;
      csr_valid <= 1'b0;
   endtask

   task automatic walk_script(input int first, input int last);
      for (int r = first; r <= last; r++) begin
         case (script[r].kind)
            ROW_READING_AT: begin
               send_reading(script[r].value, script[r].typed, script[r].result);
            end
            ROW_READING_STEP: begin
               send_reading(sent_energy + script[r].value, script[r].typed, script[r].result);
            end
            ROW_INTERVAL: begin
               write_interval(script[r].value[INTERVAL_WIDTH-1:0]);
            end
            default: begin
            end
         endcase
      end
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : receiver
      power_summary_type awaited;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_summaries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result with nothing expected: power %0h", rsp_power_now);
            end
         end else begin
            awaited = awaited_summaries.pop_front();
            check_field("power_now", awaited.power_now, rsp_power_now);
            check_field("samples_seen", awaited.samples_seen, rsp_samples_seen);
            check_field("power_lowest", awaited.power_lowest, rsp_power_lowest);
            check_field("power_highest", awaited.power_highest, rsp_power_highest);
            check_field("power_mean", awaited.power_mean, rsp_power_mean);
            check_field("squared_deviation_sum", awaited.squared_deviation_sum,
                        rsp_squared_deviation_sum);
         end
         results_taken++;
         hold_left = calm ? 0 : $urandom_range(0, 3);
         // A long hold-off lets the block fill up and stall its input.
         if (results_taken == SQUEEZE_AT) begin
            hold_left = SQUEEZE_CYCLES;
         end
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
      begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int                        bits_used;
      logic [33:0]               target;
      logic [65:0]               span;
      logic [ENERGY_WIDTH-1:0]   advance;
      logic [INTERVAL_WIDTH-1:0] phase_interval;
      // The rows that drive the squared deviation sum to its ceiling are walked last,
      // since it never comes down again.
      script = '{
         '{ROW_READING_AT,   64'hFFFF_FFFF_FFFF_F82F, 1'b0, '0},
         '{ROW_READING_AT,   64'hFFFF_FFFF_FFFF_FC17, 1'b1,
           '{48'd65536, 32'd1, 48'd65536, 48'd65536, 48'd65536, 64'd0}},
         '{ROW_READING_STEP, 64'd0,                   1'b1,
           '{48'd0, 32'd2, 48'd0, 48'd65536, 48'd32768, 64'd32768}},
         '{ROW_READING_AT,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
         '{ROW_READING_AT,   64'd0,                   1'b0, '0},
         '{ROW_READING_STEP, 64'd3500,                1'b0, '0},
         '{ROW_INTERVAL,     64'd1,                   1'b0, '0},
         '{ROW_READING_STEP, 64'd5,                   1'b0, '0},
         '{ROW_READING_STEP, 64'd0,                   1'b0, '0},
         '{ROW_INTERVAL,     64'hFFFF_FFFF,           1'b0, '0},
         '{ROW_READING_STEP, 64'hFFFF_FFFE,           1'b0, '0},
         '{ROW_READING_STEP, 64'd1,                   1'b0, '0},
         '{ROW_READING_STEP, 64'h2_0000_0000,         1'b0, '0},
         '{ROW_INTERVAL,     64'd3,                   1'b0, '0},
         '{ROW_READING_STEP, 64'd10,                  1'b0, '0},
         '{ROW_INTERVAL,     64'd1000,                1'b0, '0},
         '{ROW_INTERVAL,     64'd1000,                1'b0, '0},
         '{ROW_READING_STEP, 64'h8000_0000_0000_0000, 1'b0, '0},
         '{ROW_INTERVAL,     64'd1,                   1'b0, '0},
         '{ROW_READING_STEP, 64'hFFFF_FFFF,           1'b0, '0},
         '{ROW_READING_STEP, 64'h1_0000_0000,         1'b0, '0},
         '{ROW_INTERVAL,     64'd0,                   1'b0, '0},
         '{ROW_READING_STEP, 64'd0,                   1'b0, '0},
         '{ROW_READING_STEP, 64'd12345,               1'b0, '0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      walk_script(0, HEAD_ROWS - 1);
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: phase_interval = INTERVAL_RESET;
            1: phase_interval = 32'd1;
            2: phase_interval = '1;
            default: phase_interval = $urandom_range(32'hFFFF_FFFE, 2);
         endcase
         write_interval(phase_interval);
         calm = (phase == 2) || (phase == 5);
         // Powers are kept moderate so that the deviation sum stays clear of its ceiling.
         repeat (PHASE_ITEMS) begin
            bits_used = $urandom_range(0, 34);
            target = {2'($urandom_range(0, 3)), 32'($urandom)};
            target = target & ((34'd1 << bits_used) - 34'd1);
            span = 66'(target) * 66'(interval_cfg);
            advance = 64'(span >> FRAC) + 64'($urandom_range(0, 7));
            if ($urandom_range(0, 15) == 0) begin
               advance = '0;
            end
            send_reading(sent_energy + advance, 1'b0, '0);
         end
      end
      calm = 1'b0;
      walk_script(HEAD_ROWS, ROWS - 1);
      req_valid <= 1'b0;
      while (awaited_summaries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
